/* src/gnq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gesture note qualifier package
// Shared types, register indexes and constants for the gesture note qualifier.
// ----------------------------------------------------------------------------
package gnq_pkg;

    // Field widths of one observation and one result.
    localparam int unsigned CLASS_W = 3;
    localparam int unsigned CONF_W  = 10;
    localparam int unsigned YPOS_W  = 10;
    localparam int unsigned SEQ_W   = 32;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned BAND_W  = 2;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned GAP_W   = 16;

    // Packed stream widths, padded to whole bytes.
    localparam int unsigned IN_BITS   = 1 + CLASS_W + CONF_W + YPOS_W + SEQ_W + TIME_W;
    localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_BITS   = 1 + CLASS_W + BAND_W;
    localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CONF_LOW      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONF_HIGH     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP_MS    = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_GRACE_MS = 8'd4;

    // Register reset values.
    localparam logic [CONF_W-1:0] CONF_LOW_RST      = 10'd500;
    localparam logic [CONF_W-1:0] CONF_HIGH_RST     = 10'd800;
    localparam logic [CNT_W-1:0]  CONFIRM_COUNT_RST = 8'd2;
    localparam logic [GAP_W-1:0]  MIN_GAP_MS_RST    = 16'd120;
    localparam logic [GAP_W-1:0]  LOST_GRACE_MS_RST = 16'd350;

    // Markers for "none" and tracking constants.
    localparam logic [CLASS_W-1:0] NO_CLASS   = 3'd7;
    localparam logic [BAND_W-1:0]  NO_BAND    = 2'd3;
    localparam logic [YPOS_W-1:0]  YPOS_SAT   = 10'd1000;
    localparam logic [11:0]        BAND_DIV   = 12'd1001;
    localparam logic [11:0]        BAND_DIV2  = 12'd2002;
    localparam logic [CNT_W-1:0]   CNT_MAX    = 8'd255;
    localparam logic [SEQ_W-1:0]   SEQ_RST    = 32'hFFFF_FFFF;

    // One gesture observation.
    typedef struct packed {
        logic [TIME_W-1:0]  now_ms;
        logic [SEQ_W-1:0]   frame_seq;
        logic [YPOS_W-1:0]  ypos;
        logic [CONF_W-1:0]  confidence;
        logic [CLASS_W-1:0] gesture_class;
        logic               hand_present;
    } t_obs;

    // One qualifier result.
    typedef struct packed {
        logic [BAND_W-1:0]  pitch_band;
        logic [CLASS_W-1:0] note_class;
        logic               accepted;
    } t_note;

    // Configuration register set.
    typedef struct packed {
        logic [CONF_W-1:0] conf_low;
        logic [CONF_W-1:0] conf_high;
        logic [CNT_W-1:0]  confirm_count;
        logic [GAP_W-1:0]  min_gap_ms;
        logic [GAP_W-1:0]  lost_grace_ms;
    } t_cfg;

    // Maps a vertical position to a pitch band: 2 - (y * 3) / 1001, y saturated.
    function automatic logic [BAND_W-1:0] ypos_to_band(input logic [YPOS_W-1:0] y);
        logic [YPOS_W-1:0] y_sat;
        logic [11:0]       y3;
        y_sat = (y > YPOS_SAT) ? YPOS_SAT : y;
        y3    = {2'b00, y_sat} + {1'b0, y_sat, 1'b0};
        if (y3 >= BAND_DIV2) begin
            ypos_to_band = 2'd0;
        end else if (y3 >= BAND_DIV) begin
            ypos_to_band = 2'd1;
        end else begin
            ypos_to_band = 2'd2;
        end
    endfunction

endpackage

/* src/gnq_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gesture note qualifier input register
// Holds one observation from the input stream until the core takes it.
// ----------------------------------------------------------------------------
module gnq_in_stage
    import gnq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [IN_DATA_W-1:0] i_data,
    output logic                 o_valid,
    input  logic                 i_take,
    output t_obs                 o_obs
);

    logic r_valid;
    t_obs r_obs;

    // The register can load when it is empty or is being emptied this cycle.
    assign o_ready = !r_valid || i_take;

    // Valid flag of the held observation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload: loaded on each input transfer.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_obs <= t_obs'(i_data[IN_BITS-1:0]);
        end
    end

    assign o_valid = r_valid;
    assign o_obs   = r_obs;

endmodule

/* src/gnq_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gesture note qualifier core
// Tracking state, debounce and hold-off decision, and the result register.
// ----------------------------------------------------------------------------
module gnq_core
    import gnq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    input  t_obs  i_obs,
    output logic  o_take,
    output logic  o_valid,
    input  logic  i_ready,
    output t_note o_note
);

    // Tracking state.
    logic [CLASS_W-1:0] r_cand_class, n_cand_class;
    logic [BAND_W-1:0]  r_cand_band, n_cand_band;
    logic [CNT_W-1:0]   r_cand_frames, n_cand_frames;
    logic [CLASS_W-1:0] r_stable_class, n_stable_class;
    logic [BAND_W-1:0]  r_stable_band, n_stable_band;
    logic [TIME_W-1:0]  r_lost_since, n_lost_since;
    logic [SEQ_W-1:0]   r_last_seq, n_last_seq;
    logic [TIME_W-1:0]  r_last_note_time, n_last_note_time;

    // Result register.
    logic  r_out_valid;
    t_note r_note, n_note;

    logic               obs_ok;
    logic [BAND_W-1:0]  band;
    logic [TIME_W-1:0]  lost_start;
    logic [TIME_W-1:0]  lost_elapsed;
    logic [TIME_W-1:0]  note_elapsed;
    logic               changed;
    logic               confirmed;
    logic               held_off;

    // An item is processed when the result register is free or being drained.
    assign o_take = i_valid && (!r_out_valid || i_ready);

    assign obs_ok = i_obs.hand_present && (i_obs.gesture_class != NO_CLASS)
                    && (i_obs.confidence >= i_cfg.conf_low);
    assign band   = ypos_to_band(i_obs.ypos);

    // The lost timer starts only once a note has been played.
    assign lost_start   = ((r_stable_class != NO_CLASS) && (r_lost_since == '0))
                          ? i_obs.now_ms : r_lost_since;
    assign lost_elapsed = i_obs.now_ms - lost_start;
    assign note_elapsed = i_obs.now_ms - r_last_note_time;

    // Next-state and result logic for one observation.
    always_comb begin
        n_cand_class     = r_cand_class;
        n_cand_band      = r_cand_band;
        n_cand_frames    = r_cand_frames;
        n_stable_class   = r_stable_class;
        n_stable_band    = r_stable_band;
        n_lost_since     = r_lost_since;
        n_last_seq       = r_last_seq;
        n_last_note_time = r_last_note_time;
        n_note           = '0;
        changed          = 1'b0;
        confirmed        = 1'b0;
        held_off         = 1'b0;

        if (!obs_ok) begin
            // Weak or missing observation: run the lost timer.
            n_lost_since = lost_start;
            if ((lost_start != '0) && (lost_elapsed >= {16'd0, i_cfg.lost_grace_ms})) begin
                n_cand_class     = NO_CLASS;
                n_cand_band      = NO_BAND;
                n_cand_frames    = '0;
                n_stable_class   = NO_CLASS;
                n_stable_band    = NO_BAND;
                n_lost_since     = '0;
                n_last_seq       = SEQ_RST;
                n_last_note_time = '0;
            end
        end else begin
            n_lost_since = '0;
            if (i_obs.frame_seq != r_last_seq) begin
                n_last_seq = i_obs.frame_seq;

                // Candidate pair tracking with a saturating frame count.
                if ((i_obs.gesture_class != r_cand_class) || (band != r_cand_band)) begin
                    n_cand_class  = i_obs.gesture_class;
                    n_cand_band   = band;
                    n_cand_frames = 8'd1;
                end else if (r_cand_frames != CNT_MAX) begin
                    n_cand_frames = r_cand_frames + 8'd1;
                end

                changed   = (i_obs.gesture_class != r_stable_class)
                            || (band != r_stable_band);
                confirmed = (i_obs.confidence >= i_cfg.conf_high)
                            || (n_cand_frames >= i_cfg.confirm_count);
                held_off  = (r_last_note_time != '0)
                            && (note_elapsed < {16'd0, i_cfg.min_gap_ms});

                // A confirmed new pair outside the hold-off becomes a note.
                if (changed && confirmed && !held_off) begin
                    n_stable_class    = i_obs.gesture_class;
                    n_stable_band     = band;
                    n_last_note_time  = i_obs.now_ms;
                    n_note.accepted   = 1'b1;
                    n_note.note_class = i_obs.gesture_class;
                    n_note.pitch_band = band;
                end
            end
        end
    end

    // State update on each processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_class     <= NO_CLASS;
            r_cand_band      <= NO_BAND;
            r_cand_frames    <= '0;
            r_stable_class   <= NO_CLASS;
            r_stable_band    <= NO_BAND;
            r_lost_since     <= '0;
            r_last_seq       <= SEQ_RST;
            r_last_note_time <= '0;
        end else if (o_take) begin
            r_cand_class     <= n_cand_class;
            r_cand_band      <= n_cand_band;
            r_cand_frames    <= n_cand_frames;
            r_stable_class   <= n_stable_class;
            r_stable_band    <= n_stable_band;
            r_lost_since     <= n_lost_since;
            r_last_seq       <= n_last_seq;
            r_last_note_time <= n_last_note_time;
        end
    end

    // Result valid flag: set by a processed item, cleared by an output transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= i_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_note <= n_note;
        end
    end

    assign o_valid = r_out_valid;
    assign o_note  = r_note;

endmodule

/* src/gesture_note_qualifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gesture note qualifier
// Debounces gesture observations into notes, with confirm frames, a lost
// timer and a minimum gap between notes.
// ----------------------------------------------------------------------------
// Usage:
//   Observations arrive on the s_axis stream, one per transfer; each yields
//   exactly one result on the m_axis stream, whether or not a note was
//   accepted. Thresholds and times are set through the write port
//   (i_cfg_we, i_cfg_idx, i_cfg_data) while the stream is idle.
//   The decision logic works on the item while it sits in the input register
//   and loads the result register when that register is free or being
//   drained. Throughput is one item per cycle while the receiver does not
//   stall, as the whole decision for an item is made in a single pass
//   against the tracking registers.
//   When the receiver stalls, the result register holds its item, the input
//   register takes one more item and then s_axis_tready falls; no data is
//   lost. Synchronous reset clears both registers, the tracking state and
//   restores the register reset values.
// ----------------------------------------------------------------------------
module gesture_note_qualifier
    import gnq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream: hand_present, gesture_class, confidence, ypos, frame_seq,
    // now_ms, from bit 0 up.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Result stream: accepted, note_class, pitch_band, from bit 0 up; zero pad.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_obs  obs;
    t_note note;
    logic  obs_valid;
    logic  core_take;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.conf_low      <= CONF_LOW_RST;
            r_cfg.conf_high     <= CONF_HIGH_RST;
            r_cfg.confirm_count <= CONFIRM_COUNT_RST;
            r_cfg.min_gap_ms    <= MIN_GAP_MS_RST;
            r_cfg.lost_grace_ms <= LOST_GRACE_MS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CONF_LOW:      r_cfg.conf_low      <= i_cfg_data[CONF_W-1:0];
                CFG_CONF_HIGH:     r_cfg.conf_high     <= i_cfg_data[CONF_W-1:0];
                CFG_CONFIRM_COUNT: r_cfg.confirm_count <= i_cfg_data[CNT_W-1:0];
                CFG_MIN_GAP_MS:    r_cfg.min_gap_ms    <= i_cfg_data[GAP_W-1:0];
                CFG_LOST_GRACE_MS: r_cfg.lost_grace_ms <= i_cfg_data[GAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    gnq_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (obs_valid),
        .i_take  (core_take),
        .o_obs   (obs)
    );

    // Decision logic and result register.
    gnq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (obs_valid),
        .i_obs   (obs),
        .o_take  (core_take),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_note  (note)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - OUT_BITS){1'b0}}, note};

    // A result never appears without an observation having been held.
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(obs_valid))
        else $error("result appeared without a held observation");

    // An accepted note carries a real class and band.
    a_note_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |->
        (m_axis_tdata[3:1] != NO_CLASS) && (m_axis_tdata[5:4] != NO_BAND))
        else $error("accepted note with an invalid class or band");

    // A result without a note has zero class and band.
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[5:1] == 5'd0))
        else $error("result without a note carries non-zero fields");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

/* sim/gesture_note_qualifier_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gesture note qualifier testbench
// Drives observation transfers into the qualifier and checks every result
// transfer against a cycle-free predictor of the debounce, the confirm frame
// count, the note hold-off and the lost timer. Directed cases come first, then
// register writes, register extremes, a long confirm run and randomised traffic, with
// random idling on both streams, a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module gesture_note_qualifier_tb;
    import gnq_pkg::*;

    // Register indexes that lie beyond the register list.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX    = 8'hFF;
    localparam int unsigned RANDOM_PHASE_ITEMS = 250;
    localparam int unsigned END_WAIT_LIMIT     = 2000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // hand_present, gesture_class, confidence, ypos, frame_seq, now_ms, from bit 0 up.
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // accepted, note_class, pitch_band, from bit 0 up; zero pad above.
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // Predictor copy of the registers.
    logic [CONF_W-1:0] cfg_conf_low;
    logic [CONF_W-1:0] cfg_conf_high;
    logic [CNT_W-1:0]  cfg_confirm_count;
    logic [GAP_W-1:0]  cfg_min_gap;
    logic [GAP_W-1:0]  cfg_lost_grace;

    // Predictor copy of the tracking state.
    logic [CLASS_W-1:0] trk_cand_class;
    logic [BAND_W-1:0]  trk_cand_band;
    logic [CNT_W-1:0]   trk_cand_frames;
    logic [CLASS_W-1:0] trk_stable_class;
    logic [BAND_W-1:0]  trk_stable_band;
    logic [TIME_W-1:0]  trk_lost_since;
    logic [SEQ_W-1:0]   trk_last_seq;
    logic [TIME_W-1:0]  trk_last_note;

    // Notes predicted for observations already accepted, oldest first.
    t_note pending_notes[$];
    int unsigned error_count    = 0;
    int unsigned mismatch_count = 0;

    // Traffic control shared by the sender, the receiver and the tests.
    bit tx_idle_en    = 1'b1;
    bit rx_idle_en    = 1'b1;
    int rx_hold_cycles = 0;

    // Running content of the random observation stream.
    logic [TIME_W-1:0]  gen_now;
    logic [SEQ_W-1:0]   gen_seq;
    logic [CLASS_W-1:0] gen_class;
    logic [YPOS_W-1:0]  gen_ypos;

    gesture_note_qualifier DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Generous overall limit on the run.
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void clear_tracking();
        trk_cand_class   = NO_CLASS;
        trk_cand_band    = NO_BAND;
        trk_cand_frames  = '0;
        trk_stable_class = NO_CLASS;
        trk_stable_band  = NO_BAND;
        trk_lost_since   = '0;
        trk_last_seq     = SEQ_RST;
        trk_last_note    = '0;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_CONF_LOW:      cfg_conf_low      = data[CONF_W-1:0];
            CFG_CONF_HIGH:     cfg_conf_high     = data[CONF_W-1:0];
            CFG_CONFIRM_COUNT: cfg_confirm_count = data[CNT_W-1:0];
            CFG_MIN_GAP_MS:    cfg_min_gap       = data[GAP_W-1:0];
            CFG_LOST_GRACE_MS: cfg_lost_grace    = data[GAP_W-1:0];
            default: ;
        endcase
    endfunction

    // Works out the note for one observation and advances the tracking state.
    function automatic t_note qualify_observation(input t_obs obs);
        t_note             note;
        int unsigned       y_sat;
        logic [BAND_W-1:0] band;
        logic              changed;
        logic              confirmed;
        note = '0;
        // A weak or missing observation runs the lost timer instead.
        if (!obs.hand_present || obs.gesture_class == NO_CLASS ||
            obs.confidence < cfg_conf_low) begin
            if (trk_stable_class != NO_CLASS && trk_lost_since == '0) begin
                trk_lost_since = obs.now_ms;
            end
            if (trk_lost_since != '0 &&
                TIME_W'(obs.now_ms - trk_lost_since) >= {16'd0, cfg_lost_grace}) begin
                clear_tracking();
            end
            return note;
        end
        trk_lost_since = '0;
        if (obs.frame_seq == trk_last_seq) begin
            return note;
        end
        trk_last_seq = obs.frame_seq;

        y_sat = 32'((obs.ypos > YPOS_SAT) ? YPOS_SAT : obs.ypos);
        band  = BAND_W'(2 - (y_sat * 3) / 1001);

        // Count how often the same pair has been seen in a row.
        if (obs.gesture_class != trk_cand_class || band != trk_cand_band) begin
            trk_cand_class  = obs.gesture_class;
            trk_cand_band   = band;
            trk_cand_frames = 8'd1;
        end else if (trk_cand_frames != CNT_MAX) begin
            trk_cand_frames = trk_cand_frames + 8'd1;
        end

        changed   = (obs.gesture_class != trk_stable_class) || (band != trk_stable_band);
        confirmed = (obs.confidence >= cfg_conf_high) ||
                    (trk_cand_frames >= cfg_confirm_count);
        if (!changed || !confirmed) begin
            return note;
        end
        if (trk_last_note != '0 &&
            TIME_W'(obs.now_ms - trk_last_note) < {16'd0, cfg_min_gap}) begin
            return note;
        end
        trk_stable_class = obs.gesture_class;
        trk_stable_band  = band;
        trk_last_note    = obs.now_ms;
        note.accepted    = 1'b1;
        note.note_class  = obs.gesture_class;
        note.pitch_band  = band;
        return note;
    endfunction

    // ------------------------------------------------------------------------
    // Checking: results are compared first, then new observations and
    // register writes update the predictor, all on the same rising edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : note_checker
        t_note got;
        t_note want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[OUT_BITS-1:0];
                if (pending_notes.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("%0t: unexpected result acc=%0d cls=%0d band=%0d",
                                 $realtime, got.accepted, got.note_class, got.pitch_band);
                    end
                    mismatch_count++;
                    error_count++;
                end else begin
                    want = pending_notes.pop_front();
                    if (got.accepted !== want.accepted || got.note_class !== want.note_class ||
                        got.pitch_band !== want.pitch_band) begin
                        if (mismatch_count < 10) begin
                            $display({"%0t: mismatch expected acc=%0d cls=%0d band=%0d,",
                                      " got acc=%0d cls=%0d band=%0d"},
                                     $realtime, want.accepted, want.note_class,
                                     want.pitch_band, got.accepted, got.note_class,
                                     got.pitch_band);
                        end
                        mismatch_count++;
                        error_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pending_notes.push_back(qualify_observation(t_obs'(s_axis_tdata)));
            end
            if (i_cfg_we) begin
                apply_reg_write(i_cfg_idx, i_cfg_data);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: random stalls, or a long hold-off counted here.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_cycles = rx_hold_cycles - 1;
            end else if (rx_idle_en && $urandom_range(0, 99) < 33) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_obs make_obs(input int unsigned present,
                                      input logic [CLASS_W-1:0] cls,
                                      input int unsigned conf, input int unsigned ypos,
                                      input logic [SEQ_W-1:0] seq,
                                      input logic [TIME_W-1:0] now);
        t_obs obs;
        obs.hand_present  = (present != 0);
        obs.gesture_class = cls;
        obs.confidence    = CONF_W'(conf);
        obs.ypos          = YPOS_W'(ypos);
        obs.frame_seq     = seq;
        obs.now_ms        = now;
        return obs;
    endfunction

    // Sends one observation, at times after a random idle gap, and returns
    // at the rising edge of its transfer.
    task automatic send_obs(input t_obs obs);
        int unsigned gap;
        if (tx_idle_en && $urandom_range(0, 99) < 33) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= obs;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stops sending and waits until every predicted note has arrived.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_notes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic program_regs(input int unsigned low, input int unsigned high,
                                input int unsigned count, input int unsigned gap_ms,
                                input int unsigned grace_ms);
        drain_results();
        write_reg(CFG_CONF_LOW, CFG_DATA_W'(low));
        write_reg(CFG_CONF_HIGH, CFG_DATA_W'(high));
        write_reg(CFG_CONFIRM_COUNT, CFG_DATA_W'(count));
        write_reg(CFG_MIN_GAP_MS, CFG_DATA_W'(gap_ms));
        write_reg(CFG_LOST_GRACE_MS, CFG_DATA_W'(grace_ms));
    endtask

    // Starts a fresh random stream, sometimes just below the time wrap.
    function automatic void restart_stream();
        gen_now   = ($urandom_range(0, 1) == 0) ? $urandom : 32'hFFFF_F000;
        gen_seq   = $urandom;
        gen_class = CLASS_W'($urandom_range(0, 6));
        gen_ypos  = YPOS_W'($urandom_range(0, 1023));
    endfunction

    // Mostly a plausible frame stream: advancing time and sequence, pairs
    // that repeat, confidence spread around the thresholds. The rest is noise.
    function automatic t_obs random_obs();
        t_obs         obs;
        logic [95:0]  raw;
        int unsigned  pick;
        int unsigned  conf;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            raw = {$urandom, $urandom, $urandom};
            obs = raw[IN_BITS-1:0];
            return obs;
        end

        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            gen_now = gen_now + $urandom_range(0, 40);
        end else if (pick < 90) begin
            gen_now = gen_now + $urandom_range(0, 400);
        end else if (pick < 98) begin
            gen_now = gen_now + $urandom_range(0, 70000);
        end else begin
            gen_now = $urandom;
        end

        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            gen_seq = gen_seq;
        end else if (pick < 10) begin
            gen_seq = $urandom;
        end else begin
            gen_seq = gen_seq + 32'd1;
        end

        if ($urandom_range(0, 99) < 35) begin
            gen_class = CLASS_W'($urandom_range(0, 6));
            gen_ypos  = YPOS_W'($urandom_range(0, 1023));
        end

        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            conf = $urandom_range(cfg_conf_high, 1023);
        end else if (pick < 75) begin
            conf = $urandom_range(cfg_conf_low, cfg_conf_high);
        end else if (pick < 90) begin
            conf = $urandom_range(0, 1023);
        end else begin
            conf = $urandom_range(0, cfg_conf_low);
        end

        obs = make_obs(($urandom_range(0, 99) >= 4) ? 1 : 0, gen_class, conf, gen_ypos,
                       gen_seq, gen_now);
        if ($urandom_range(0, 99) < 2) begin
            obs.gesture_class = NO_CLASS;
        end
        return obs;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-picked frames under the reset register values.
    task automatic test_directed_defaults();
        // All-ones sequence straight after reset counts as a repeat.
        send_obs(make_obs(1, 3'd3, 900, 500, 32'hFFFF_FFFF, 32'd100));
        // High confidence note at time zero, lowest position.
        send_obs(make_obs(1, 3'd3, 900, 0, 32'd1, 32'd0));
        // A note at time zero leaves no hold-off; position saturated.
        send_obs(make_obs(1, 3'd4, 900, 1023, 32'd2, 32'd10));
        // Held off by the minimum gap.
        send_obs(make_obs(1, 3'd5, 900, 333, 32'd3, 32'd50));
        // Mid band by one frame, confirmed by the second.
        send_obs(make_obs(1, 3'd5, 600, 334, 32'd4, 32'd200));
        send_obs(make_obs(1, 3'd5, 600, 667, 32'd5, 32'd210));
        // Repeated sequence number.
        send_obs(make_obs(1, 3'd5, 600, 667, 32'd5, 32'd220));
        // Loss: absent hand, invalid class and weak confidence, then expiry.
        send_obs(make_obs(0, 3'd5, 900, 667, 32'd6, 32'd300));
        send_obs(make_obs(1, NO_CLASS, 900, 100, 32'd7, 32'd400));
        send_obs(make_obs(1, 3'd2, 499, 100, 32'd8, 32'd649));
        send_obs(make_obs(1, 3'd2, 499, 100, 32'd9, 32'd650));
        // Fresh tracking after expiry, then a band change inside the gap.
        send_obs(make_obs(1, 3'd5, 900, 667, 32'd10, 32'd660));
        send_obs(make_obs(1, 3'd5, 900, 668, 32'd11, 32'd670));
        // Loss starting at time zero is treated as not started.
        send_obs(make_obs(0, 3'd0, 0, 0, 32'd0, 32'd0));
        send_obs(make_obs(0, 3'd0, 0, 0, 32'd0, 32'd1000));
        // Time wrap, confidence at its top and exactly at the thresholds.
        send_obs(make_obs(1, 3'd1, 1023, 1000, 32'hFFFF_FFFE, 32'hFFFF_FFF0));
        send_obs(make_obs(1, 3'd6, 800, 1001, 32'hFFFF_FFFF, 32'h0000_0020));
        send_obs(make_obs(1, 3'd6, 800, 1001, 32'd0, 32'h0000_0068));
        send_obs(make_obs(1, 3'd6, 500, 1001, 32'd1, 32'h0000_0100));
        // Alternating bit patterns in sequence and time; the second frame also in confidence and position.
        send_obs(make_obs(1, 3'd0, 1023, 511, 32'hAAAA_AAAA, 32'h5555_5555));
        send_obs(make_obs(1, 3'd2, 682, 341, 32'h5555_5555, 32'hAAAA_AAAA));
        drain_results();
    endtask

    // Upper data bits are dropped and writes outside the list do nothing.
    task automatic test_register_writes();
        int unsigned n;
        drain_results();
        write_reg(CFG_CONF_LOW, 16'hFC00 | 16'd300);
        write_reg(CFG_CONF_HIGH, 16'hA400 | 16'd700);
        write_reg(CFG_CONFIRM_COUNT, 16'h0103);
        write_reg(CFG_MIN_GAP_MS, 16'd60);
        write_reg(CFG_LOST_GRACE_MS, 16'd150);
        write_reg(CFG_UNUSED_IDX, 16'hFFFF);
        write_reg(CFG_TOP_IDX, 16'h0000);
        restart_stream();
        for (n = 0; n < 30; n++) begin
            send_obs(random_obs());
        end
        drain_results();
    endtask

    // Short bursts under the extreme register settings.
    task automatic test_register_extremes();
        int unsigned n;
        int unsigned k;
        for (k = 0; k < 5; k++) begin
            case (k)
                0: program_regs(0, 0, 0, 0, 0);
                1: program_regs(1023, 1023, 255, 65535, 65535);
                2: program_regs(0, 1023, 1, 65535, 0);
                3: program_regs(1023, 0, 0, 0, 65535);
                default: program_regs(1, 1022, 2, 1, 1);
            endcase
            restart_stream();
            for (n = 0; n < 30; n++) begin
                send_obs(random_obs());
            end
        end
        drain_results();
    endtask

    // A pair repeated past 255 frames keeps its count at the top, so it is
    // still confirmed once the hold-off has run out.
    task automatic test_confirm_saturation();
        int unsigned n;
        program_regs(500, 1023, 255, 65535, 65535);
        send_obs(make_obs(1, 3'd1, 1023, 0, 32'd100, 32'd5));
        for (n = 0; n < 300; n++) begin
            send_obs(make_obs(1, 3'd2, 600, 0, 32'd101 + n, 32'd10 + n));
        end
        send_obs(make_obs(1, 3'd2, 600, 0, 32'd500, 32'd65540));
        send_obs(make_obs(1, 3'd2, 600, 0, 32'd501, 32'd65600));
        drain_results();
    endtask

    // Random traffic over several register settings, with back pressure.
    task automatic test_random_traffic();
        int unsigned n;
        int unsigned p;
        for (p = 0; p < 5; p++) begin
            case (p)
                0: program_regs(CONF_LOW_RST, CONF_HIGH_RST, CONFIRM_COUNT_RST,
                                MIN_GAP_MS_RST, LOST_GRACE_MS_RST);
                1: program_regs(300, 600, 3, 40, 200);
                2: program_regs($urandom_range(0, 1023), $urandom_range(0, 1023),
                                $urandom_range(0, 255), $urandom_range(0, 65535),
                                $urandom_range(0, 65535));
                3: program_regs(100, 900, 5, 250, 1000);
                default: program_regs(700, 750, 1, 10, 60);
            endcase
            restart_stream();
            // One whole phase with no idling on either side.
            tx_idle_en = (p != 1);
            rx_idle_en = (p != 1);
            for (n = 0; n < RANDOM_PHASE_ITEMS; n++) begin
                if (p == 0 && n == 100) begin
                    // Long receiver hold-off while the sender keeps offering.
                    rx_hold_cycles = 300;
                end
                if (p == 0 && n == 200) begin
                    // Sender pauses until every note is back.
                    drain_results();
                end
                send_obs(random_obs());
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned wait_cycles;
        cfg_conf_low      = CONF_LOW_RST;
        cfg_conf_high     = CONF_HIGH_RST;
        cfg_confirm_count = CONFIRM_COUNT_RST;
        cfg_min_gap       = MIN_GAP_MS_RST;
        cfg_lost_grace    = LOST_GRACE_MS_RST;
        clear_tracking();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_defaults();
        test_register_writes();
        test_register_extremes();
        test_confirm_saturation();
        test_random_traffic();

        // Final wait for outstanding notes, bounded.
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < END_WAIT_LIMIT && pending_notes.size() != 0;
             wait_cycles++) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (pending_notes.size() != 0) begin
            $display("%0d expected results never arrived", pending_notes.size());
            error_count += pending_notes.size();
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
